### rtl/masked_3d_value_dilation_assert.svh
// assertion macros used by rtl/masked_3d_value_dilation.sv
`ifndef MASKED_3D_VALUE_DILATION_ASSERT_SVH
`define MASKED_3D_VALUE_DILATION_ASSERT_SVH

// same-cycle implication, checked outside reset
`define M3VD_ASSERT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("m3vd same-cycle check failed");

// next-cycle implication, checked outside reset
`define M3VD_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("m3vd next-cycle check failed");

`endif

### rtl/m3vd_pkg.sv
`timescale 1ns / 1ps
package m3vd_pkg;
    localparam int SAMPLE_W    = 8;
    localparam int MAX_W       = 256;
    localparam int MAX_H       = 256;
    localparam int MAX_D       = 4096;
    localparam int DIM_W       = 9;
    localparam int DEPTH_W     = 13;
    localparam int MASK_W      = 27;
    localparam int CFG_DATA_W  = 27;
    localparam int CFG_IDX_W   = 3;
    localparam int XPOS_W      = $clog2(MAX_W);
    localparam int YPOS_W      = $clog2(MAX_H);
    localparam int ZPOS_W      = $clog2(MAX_D);
    localparam int LINE_DEPTH  = MAX_W;
    localparam int PLANE_DEPTH = MAX_W * MAX_H;
    localparam int LINE_PTR_W  = $clog2(LINE_DEPTH);
    localparam int PLANE_PTR_W = $clog2(PLANE_DEPTH);
    localparam int PLANE_LEN_W = PLANE_PTR_W + 1;
    localparam int LAG_W       = $clog2(PLANE_DEPTH + MAX_W + 2);

    typedef logic [SAMPLE_W-1:0]  t_sample;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_DILATE = 3'd0;
    localparam t_cfg_idx CFG_ERODE  = 3'd1;
    localparam t_cfg_idx CFG_MASK   = 3'd2;
    localparam t_cfg_idx CFG_WIDTH  = 3'd3;
    localparam t_cfg_idx CFG_HEIGHT = 3'd4;
    localparam t_cfg_idx CFG_DEPTH  = 3'd5;

    localparam t_sample           RST_DILATE = 8'd0;
    localparam t_sample           RST_ERODE  = 8'd255;
    localparam logic [MASK_W-1:0] RST_MASK   = 27'd8192;
    localparam logic [DIM_W-1:0]  RST_WIDTH  = 9'd256;
    localparam logic [DIM_W-1:0]  RST_HEIGHT = 9'd256;
    localparam logic [DEPTH_W-1:0] RST_DEPTH = 13'd256;
    localparam logic [PLANE_LEN_W-1:0] RST_WH =
        PLANE_LEN_W'(int'(RST_WIDTH) * int'(RST_HEIGHT));
    localparam logic [LAG_W-1:0] RST_LAG =
        LAG_W'(int'(RST_WIDTH) * int'(RST_HEIGHT) + int'(RST_WIDTH) + 1);
endpackage

### rtl/m3vd_in_if.sv
`timescale 1ns / 1ps
interface m3vd_in_if;
    logic                   valid;
    logic                   ready;
    logic                   command;
    m3vd_pkg::t_sample      voxel_in;
    modport source (output valid, command, voxel_in, input ready);
    modport sink (input valid, command, voxel_in, output ready);
endinterface

### rtl/m3vd_out_if.sv
`timescale 1ns / 1ps
interface m3vd_out_if;
    logic                   valid;
    logic                   ready;
    m3vd_pkg::t_sample      voxel_out;
    logic                   volume_last;
    modport source (output valid, voxel_out, volume_last, input ready);
    modport sink (input valid, voxel_out, volume_last, output ready);
endinterface

### rtl/masked_3d_value_dilation.sv
`timescale 1ns / 1ps
// Masked 3x3x3 value dilation of a raster-order voxel stream (x fastest, then y, then z).
// One request is taken every clock while the output side keeps up, and a stalled output
// holds the whole pipeline. The first W*H+W+1 requests of a volume (one plane, one row and
// one voxel ahead of the center) release nothing. Each later request releases one result,
// which passes through the stage 1 registers and then the output register. The window
// comes from two plane buffers of W*H and W*H-1 samples and six line buffers of W samples
// (the first) or W-1 samples (the rest), each a single-port ring advanced per request,
// plus a 3-deep shift register per row. Send flush requests (command = 1) after the last
// voxel to drain the final W*H+W+1 results. Write the geometry registers only while the
// block is idle; a geometry write drops any partial volume.
`include "masked_3d_value_dilation_assert.svh"
module masked_3d_value_dilation (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    m3vd_in_if.sink                             i_in,
    m3vd_out_if.source                          o_out,
    input  logic                                i_cfg_we,
    input  m3vd_pkg::t_cfg_idx                  i_cfg_idx,
    input  logic [m3vd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    localparam int SW  = m3vd_pkg::SAMPLE_W;
    localparam int LPW = m3vd_pkg::LINE_PTR_W;
    localparam int PPW = m3vd_pkg::PLANE_PTR_W;
    localparam int PLW = m3vd_pkg::PLANE_LEN_W;
    localparam int DW  = m3vd_pkg::DIM_W;

    // configuration, geometry stored already clamped
    m3vd_pkg::t_sample                  r_dil;
    m3vd_pkg::t_sample                  r_ero;
    logic [m3vd_pkg::MASK_W-1:0]        r_mask;
    logic [DW-1:0]                      r_w;
    logic [DW-1:0]                      r_h;
    logic [m3vd_pkg::DEPTH_W-1:0]       r_d;
    logic [PLW-1:0]                     r_wh;
    logic [m3vd_pkg::LAG_W-1:0]         r_lag;

    logic [m3vd_pkg::LAG_W-1:0]         r_fill;
    logic [m3vd_pkg::XPOS_W-1:0]        r_x;
    logic [m3vd_pkg::YPOS_W-1:0]        r_y;
    logic [m3vd_pkg::ZPOS_W-1:0]        r_z;

    logic                               acc;
    logic                               en;
    logic                               emit;
    logic                               last;
    m3vd_pkg::t_sample                  s_in;
    logic [m3vd_pkg::XPOS_W-1:0]        w_m1;
    logic [m3vd_pkg::YPOS_W-1:0]        h_m1;
    logic [m3vd_pkg::ZPOS_W-1:0]        d_m1;
    logic [DW-1:0]                      n_w;
    logic [DW-1:0]                      n_h;
    logic [m3vd_pkg::DEPTH_W-1:0]       n_d;
    logic                               geo_we;
    logic [DW-1:0]                      c_w;
    logic [DW-1:0]                      c_h;
    logic [PLW-1:0]                     c_wh;

    // stage 1: window registers and position flags
    logic                               r_s1_v;
    logic                               r_s1_last;
    logic                               r_s1_xlo, r_s1_xhi;
    logic                               r_s1_ylo, r_s1_yhi;
    logic                               r_s1_zlo, r_s1_zhi;
    m3vd_pkg::t_sample                  r_s0;

    // output register
    logic                               r_ov;
    m3vd_pkg::t_sample                  r_vo;
    logic                               r_lo;

    m3vd_pkg::t_sample                  ltap [6];
    m3vd_pkg::t_sample                  ptap [2];
    m3vd_pkg::t_sample                  rstart [9];
    m3vd_pkg::t_sample                  r_d1 [9];
    m3vd_pkg::t_sample                  r_d2 [9];
    m3vd_pkg::t_sample                  win [27];
    logic                               hit;
    m3vd_pkg::t_sample                  res;

    assign acc  = i_in.valid && i_in.ready;
    assign en   = !r_ov || o_out.ready;
    assign i_in.ready = en;
    assign s_in = i_in.command ? '0 : i_in.voxel_in;

    assign w_m1 = m3vd_pkg::XPOS_W'(r_w - DW'(1));
    assign h_m1 = m3vd_pkg::YPOS_W'(r_h - DW'(1));
    assign d_m1 = m3vd_pkg::ZPOS_W'(r_d - m3vd_pkg::DEPTH_W'(1));
    assign emit = (r_fill == r_lag);
    assign last = (r_x == w_m1) && (r_y == h_m1) && (r_z == d_m1);

    // geometry seen after this edge, so plane size and lag follow a write at once
    assign geo_we = i_cfg_we && ((i_cfg_idx == m3vd_pkg::CFG_WIDTH) ||
                                 (i_cfg_idx == m3vd_pkg::CFG_HEIGHT) ||
                                 (i_cfg_idx == m3vd_pkg::CFG_DEPTH));
    assign c_w  = (i_cfg_we && (i_cfg_idx == m3vd_pkg::CFG_WIDTH)) ? n_w : r_w;
    assign c_h  = (i_cfg_we && (i_cfg_idx == m3vd_pkg::CFG_HEIGHT)) ? n_h : r_h;
    assign c_wh = PLW'(c_w) * PLW'(c_h);

    always_comb begin
        n_w = i_cfg_data[DW-1:0];
        if (n_w == '0) begin
            n_w = DW'(1);
        end else if (n_w > DW'(m3vd_pkg::MAX_W)) begin
            n_w = DW'(m3vd_pkg::MAX_W);
        end
        n_h = i_cfg_data[DW-1:0];
        if (n_h == '0) begin
            n_h = DW'(1);
        end else if (n_h > DW'(m3vd_pkg::MAX_H)) begin
            n_h = DW'(m3vd_pkg::MAX_H);
        end
        n_d = i_cfg_data[m3vd_pkg::DEPTH_W-1:0];
        if (n_d == '0) begin
            n_d = m3vd_pkg::DEPTH_W'(1);
        end else if (n_d > m3vd_pkg::DEPTH_W'(m3vd_pkg::MAX_D)) begin
            n_d = m3vd_pkg::DEPTH_W'(m3vd_pkg::MAX_D);
        end
    end

    // line buffers: unit 2*dz+dy-1 yields the start of row dy in plane dz
    genvar gi;
    generate
        for (gi = 0; gi < 6; gi++) begin : g_line
            logic [LPW-1:0] r_ptr;
            logic [DW-1:0]  len;
            m3vd_pkg::t_sample din;
            m3vd_pkg::t_sample q;
            m3vd_pkg::t_sample r_byp;

            if (gi == 0) begin : g_src
                assign din = s_in;
                assign len = r_w;
            end else if (gi % 2 == 0) begin : g_src
                assign din = ptap[gi/2-1];
                assign len = r_w - DW'(1);
            end else begin : g_src
                assign din = ltap[gi-1];
                assign len = r_w - DW'(1);
            end

            m3vd_ram #(.DEPTH(m3vd_pkg::LINE_DEPTH), .WIDTH(SW)) u_ram (
                .i_clk   (i_clk),
                .i_en    (acc),
                .i_addr  (r_ptr),
                .i_wdata (din),
                .o_rdata (q)
            );

            // a new geometry restarts the ring so no slot falls outside it
            always_ff @(posedge i_clk) begin
                if (!i_rst_n || geo_we) begin
                    r_ptr <= '0;
                end else if (acc) begin
                    if ({1'b0, r_ptr} >= len - DW'(1)) begin
                        r_ptr <= '0;
                    end else begin
                        r_ptr <= r_ptr + LPW'(1);
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (acc) begin
                    r_byp <= din;
                end
            end

            // a zero-length line (width 1) is just a register
            assign ltap[gi] = (len == '0) ? r_byp : q;
        end

        for (gi = 0; gi < 2; gi++) begin : g_plane
            logic [PPW-1:0] r_ptr;
            logic [PLW-1:0] len;
            m3vd_pkg::t_sample din;
            m3vd_pkg::t_sample q;
            m3vd_pkg::t_sample r_byp;

            if (gi == 0) begin : g_src
                assign din = s_in;
                assign len = r_wh;
            end else begin : g_src
                assign din = ptap[0];
                assign len = r_wh - PLW'(1);
            end

            m3vd_ram #(.DEPTH(m3vd_pkg::PLANE_DEPTH), .WIDTH(SW)) u_ram (
                .i_clk   (i_clk),
                .i_en    (acc),
                .i_addr  (r_ptr),
                .i_wdata (din),
                .o_rdata (q)
            );

            always_ff @(posedge i_clk) begin
                if (!i_rst_n || geo_we) begin
                    r_ptr <= '0;
                end else if (acc) begin
                    if ({1'b0, r_ptr} >= len - PLW'(1)) begin
                        r_ptr <= '0;
                    end else begin
                        r_ptr <= r_ptr + PPW'(1);
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (acc) begin
                    r_byp <= din;
                end
            end

            assign ptap[gi] = (len == '0) ? r_byp : q;
        end

        for (gi = 0; gi < 9; gi++) begin : g_row
            if (gi == 0) begin : g_start
                assign rstart[gi] = r_s0;
            end else if (gi % 3 == 0) begin : g_start
                assign rstart[gi] = ptap[gi/3-1];
            end else begin : g_start
                assign rstart[gi] = ltap[(gi/3)*2 + gi%3 - 1];
            end

            always_ff @(posedge i_clk) begin
                if (acc) begin
                    r_d1[gi] <= rstart[gi];
                    r_d2[gi] <= r_d1[gi];
                end
            end

            assign win[gi*3]     = rstart[gi];
            assign win[gi*3 + 1] = r_d1[gi];
            assign win[gi*3 + 2] = r_d2[gi];
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s0 <= s_in;
        end
    end

    // window slot i holds kernel offset 26-i; oldest samples sit at high dz
    always_comb begin
        logic zok, yok, xok;
        hit = 1'b0;
        for (int i = 0; i < 27; i++) begin
            zok = (i / 9 == 0) ? r_s1_zhi : ((i / 9 == 2) ? r_s1_zlo : 1'b1);
            yok = ((i / 3) % 3 == 0) ? r_s1_yhi : (((i / 3) % 3 == 2) ? r_s1_ylo : 1'b1);
            xok = (i % 3 == 0) ? r_s1_xhi : ((i % 3 == 2) ? r_s1_xlo : 1'b1);
            if (r_mask[26 - i] && zok && yok && xok && (win[i] == r_dil)) begin
                hit = 1'b1;
            end
        end
        res = ((win[13] == r_ero) && hit) ? r_dil : win[13];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dil  <= m3vd_pkg::RST_DILATE;
            r_ero  <= m3vd_pkg::RST_ERODE;
            r_mask <= m3vd_pkg::RST_MASK;
            r_w    <= m3vd_pkg::RST_WIDTH;
            r_h    <= m3vd_pkg::RST_HEIGHT;
            r_d    <= m3vd_pkg::RST_DEPTH;
            r_wh   <= m3vd_pkg::RST_WH;
            r_lag  <= m3vd_pkg::RST_LAG;
            r_fill <= '0;
            r_x    <= '0;
            r_y    <= '0;
            r_z    <= '0;
            r_s1_v <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_wh  <= c_wh;
            r_lag <= m3vd_pkg::LAG_W'(c_wh) + m3vd_pkg::LAG_W'(c_w) + m3vd_pkg::LAG_W'(1);

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    m3vd_pkg::CFG_DILATE: r_dil  <= i_cfg_data[SW-1:0];
                    m3vd_pkg::CFG_ERODE:  r_ero  <= i_cfg_data[SW-1:0];
                    m3vd_pkg::CFG_MASK:   r_mask <= i_cfg_data[m3vd_pkg::MASK_W-1:0];
                    m3vd_pkg::CFG_WIDTH: begin
                        r_w    <= n_w;
                        r_fill <= '0;
                        r_x    <= '0;
                        r_y    <= '0;
                        r_z    <= '0;
                    end
                    m3vd_pkg::CFG_HEIGHT: begin
                        r_h    <= n_h;
                        r_fill <= '0;
                        r_x    <= '0;
                        r_y    <= '0;
                        r_z    <= '0;
                    end
                    m3vd_pkg::CFG_DEPTH: begin
                        r_d    <= n_d;
                        r_fill <= '0;
                        r_x    <= '0;
                        r_y    <= '0;
                        r_z    <= '0;
                    end
                    default: begin
                    end
                endcase
            end else if (acc) begin
                if (!emit) begin
                    r_fill <= r_fill + m3vd_pkg::LAG_W'(1);
                end else if (last) begin
                    r_fill <= '0;
                    r_x    <= '0;
                    r_y    <= '0;
                    r_z    <= '0;
                end else if (r_x != w_m1) begin
                    r_x <= r_x + m3vd_pkg::XPOS_W'(1);
                end else begin
                    r_x <= '0;
                    if (r_y != h_m1) begin
                        r_y <= r_y + m3vd_pkg::YPOS_W'(1);
                    end else begin
                        r_y <= '0;
                        r_z <= r_z + m3vd_pkg::ZPOS_W'(1);
                    end
                end
            end

            if (en) begin
                r_s1_v <= acc && emit;
                r_ov   <= r_s1_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_last <= last;
            r_s1_xlo  <= (r_x != '0);
            r_s1_xhi  <= (r_x != w_m1);
            r_s1_ylo  <= (r_y != '0);
            r_s1_yhi  <= (r_y != h_m1);
            r_s1_zlo  <= (r_z != '0);
            r_s1_zhi  <= (r_z != d_m1);
            r_vo      <= res;
            r_lo      <= r_s1_last;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.voxel_out   = r_vo;
    assign o_out.volume_last = r_lo;

    `M3VD_ASSERT(a_fill_bound, 1'b1, r_fill <= r_lag)
    `M3VD_ASSERT(a_x_in_row, 1'b1, r_x <= w_m1)
    `M3VD_ASSERT_NEXT(a_last_restarts, acc && emit && last, (r_fill == '0) && (r_x == '0))
endmodule

### rtl/m3vd_ram.sv
`timescale 1ns / 1ps
module m3vd_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-before-write on the same slot gives a ring delay
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rdata        <= r_mem[i_addr];
            r_mem[i_addr]  <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;
endmodule
